### rtl/tpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timer priority queue package
// Shared types and codes for the sorted timer cell chain.
// ----------------------------------------------------------------------------
package tpq_pkg;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_ADJUST = 3'd1,
    OP_REMOVE = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_POLL   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_FIRE = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DELETE,
    S_INSERT,
    S_POLL,
    S_OUT
  } state_t;

  localparam int MAX_FIRE = 16;
  localparam logic [30:0] WAIT_MAX = 31'h7FFF_FFFF;

endpackage
`default_nettype wire

### rtl/tpq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timer queue cell
// Holds one sorted entry; shifts toward its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module tpq_cell #(
  parameter int ID_BITS   = 16,
  parameter int TIME_BITS = 48
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  tpq_pkg::cmd_t        cmd,
  input  wire [ID_BITS-1:0]    new_id,
  input  wire [TIME_BITS-1:0]  new_exp,
  input  wire                  del_here_or_before,
  input  wire                  prev_valid,
  input  wire                  prev_after,
  input  wire [ID_BITS-1:0]    prev_id,
  input  wire [TIME_BITS-1:0]  prev_exp,
  input  wire                  next_valid,
  input  wire [ID_BITS-1:0]    next_id,
  input  wire [TIME_BITS-1:0]  next_exp,
  output logic                 valid,
  output logic                 after,
  output logic [ID_BITS-1:0]   id,
  output logic [TIME_BITS-1:0] exp
);
  import tpq_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [TIME_BITS-1:0] exp_r, exp_nxt;

  assign valid = valid_r;
  assign id    = id_r;
  assign exp   = exp_r;
  assign after = valid_r &&
                 ((new_exp < exp_r) || ((new_exp == exp_r) && (new_id < id_r)));

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    exp_nxt   = exp_r;
    case (cmd)
      CMD_INSERT: begin
        if (prev_after) begin
          valid_nxt = prev_valid;
          id_nxt    = prev_id;
          exp_nxt   = prev_exp;
        end else if (after || !valid_r) begin
          if (prev_valid) begin
            valid_nxt = 1'b1;
            id_nxt    = new_id;
            exp_nxt   = new_exp;
          end
        end
      end
      CMD_DELETE: begin
        if (del_here_or_before) begin
          valid_nxt = next_valid;
          id_nxt    = next_id;
          exp_nxt   = next_exp;
        end
      end
      CMD_CLEAR: valid_nxt = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    id_r  <= id_nxt;
    exp_r <= exp_nxt;
  end

endmodule
`default_nettype wire

### rtl/timer_priority_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timer priority queue unit
// Sorted chain of timer cells with a sequencer for add, adjust, remove,
// clear and poll requests.
// ----------------------------------------------------------------------------
// Requests run one at a time: in_stall is high until the sequencer is idle
// again, and a stalled output holds a request. A poll gives one fire result
// per expired timer, up to MAX_FIRE, then an end result.
// Reset empties the queue and restarts ids at zero; no clearing pass.
// ----------------------------------------------------------------------------
module timer_priority_queue_unit #(
  parameter int CAPACITY  = 16,
  parameter int ID_BITS   = 16,
  parameter int TIME_BITS = 48
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [2:0]  in_opcode,
  input  wire  [47:0] in_current_ms,
  input  wire  [15:0] in_task_id,
  input  wire  signed [31:0] in_delay_ms,
  input  wire         in_fire_on_remove,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_status,
  output logic [15:0] out_result_id,
  output logic        out_fired,
  output logic [30:0] out_wait_ms,
  output logic [4:0]  out_timer_count,
  output logic        out_last
);
  import tpq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FW = $clog2(MAX_FIRE + 1);

  state_t state_r, state_nxt;
  logic [2:0]           op_r;
  logic [TIME_BITS-1:0] now_r;
  logic [ID_BITS-1:0]   tid_r;
  logic [31:0]          delay_r;
  logic                 fire_r;
  logic [CW-1:0]        count_r, count_nxt;
  logic [ID_BITS-1:0]   nid_r, nid_nxt;
  logic [FW-1:0]        nfire_r, nfire_nxt;
  logic [PW-1:0]        pos_r, pos_nxt;
  logic [ID_BITS-1:0]   ins_id_r, ins_id_nxt;
  logic [TIME_BITS-1:0] ins_exp_r, ins_exp_nxt;
  logic                 o_valid_r, o_valid_nxt;
  logic [1:0]           o_kind_r, o_kind_nxt, o_stat_r, o_stat_nxt;
  logic [15:0]          o_id_r, o_id_nxt;
  logic                 o_fired_r, o_fired_nxt, o_last_r, o_last_nxt;
  logic [30:0]          o_wait_r, o_wait_nxt;
  cmd_t                 cmd;

  logic [CAPACITY-1:0]  c_valid, c_after, c_match, c_delsel;
  logic [ID_BITS-1:0]   c_id  [CAPACITY];
  logic [TIME_BITS-1:0] c_exp [CAPACITY];

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic                 pv, pa, nv;
      logic [ID_BITS-1:0]   pid, nidw;
      logic [TIME_BITS-1:0] pexp, nexp;
      if (g == 0) begin : g_first
        assign pv = 1'b1; assign pa = 1'b0;
        assign pid = ins_id_r; assign pexp = ins_exp_r;
        assign c_delsel[g] = (pos_r == PW'(g));
      end else begin : g_mid
        assign pv = c_valid[g-1]; assign pa = c_after[g-1];
        assign pid = c_id[g-1]; assign pexp = c_exp[g-1];
        assign c_delsel[g] = c_delsel[g-1] || (pos_r == PW'(g));
      end
      if (g == CAPACITY - 1) begin : g_last
        assign nv = 1'b0; assign nidw = '0; assign nexp = '0;
      end else begin : g_inner
        assign nv = c_valid[g+1]; assign nidw = c_id[g+1]; assign nexp = c_exp[g+1];
      end
      assign c_match[g] = c_valid[g] && (c_id[g] == tid_r);
      tpq_cell #(.ID_BITS(ID_BITS), .TIME_BITS(TIME_BITS)) u_cell (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .new_id(ins_id_r), .new_exp(ins_exp_r),
        .del_here_or_before(c_delsel[g]),
        .prev_valid(pv), .prev_after(pa), .prev_id(pid), .prev_exp(pexp),
        .next_valid(nv), .next_id(nidw), .next_exp(nexp),
        .valid(c_valid[g]), .after(c_after[g]), .id(c_id[g]), .exp(c_exp[g])
      );
    end
  endgenerate

  logic [PW-1:0] hit_pos;
  logic          hit;
  always_comb begin
    hit_pos = '0;
    hit = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (c_match[i]) begin
        hit = 1'b1;
        hit_pos = PW'(i);
      end
    end
  end

  function automatic logic [TIME_BITS-1:0] shift_t(input logic [TIME_BITS-1:0] t,
                                                   input logic [31:0] d);
    logic [TIME_BITS:0] s;
    logic [31:0]        mag;
    s = '0;
    mag = '0;
    if (d[31]) begin
      mag = 32'd0 - d;
      if ({1'b0, t} >= (TIME_BITS+1)'(mag)) s = {1'b0, t} - (TIME_BITS+1)'(mag);
      else s = '0;
    end else begin
      s = {1'b0, t} + (TIME_BITS+1)'(d);
      if (s[TIME_BITS]) s = {1'b0, {TIME_BITS{1'b1}}};
    end
    return s[TIME_BITS-1:0];
  endfunction

  logic [TIME_BITS-1:0] head_diff;
  assign head_diff = c_exp[0] - now_r;

  assign in_stall = (state_r != S_IDLE);
  assign out_valid       = o_valid_r;
  assign out_kind        = o_kind_r;
  assign out_status      = o_stat_r;
  assign out_result_id   = o_id_r;
  assign out_fired       = o_fired_r;
  assign out_wait_ms     = o_wait_r;
  assign out_timer_count = 5'(count_r);
  assign out_last        = o_last_r;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    nid_nxt     = nid_r;
    nfire_nxt   = nfire_r;
    pos_nxt     = pos_r;
    ins_id_nxt  = ins_id_r;
    ins_exp_nxt = ins_exp_r;
    o_valid_nxt = o_valid_r && out_stall;
    o_kind_nxt  = o_kind_r;
    o_stat_nxt  = o_stat_r;
    o_id_nxt    = o_id_r;
    o_fired_nxt = o_fired_r;
    o_wait_nxt  = o_wait_r;
    o_last_nxt  = o_last_r;
    cmd         = CMD_HOLD;
    o_kind_nxt  = o_valid_nxt ? o_kind_r : KIND_ACK;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SEARCH;
          nfire_nxt = '0;
        end
      end
      S_SEARCH: begin
        if (!o_valid_nxt) begin
          o_kind_nxt  = KIND_ACK;
          o_stat_nxt  = ST_OK;
          o_id_nxt    = 16'(tid_r);
          o_fired_nxt = 1'b0;
          o_wait_nxt  = '0;
          o_last_nxt  = 1'b1;
          state_nxt   = S_OUT;
          case (op_r)
            OP_ADD: begin
              if (count_r >= CW'(CAPACITY)) begin
                o_stat_nxt = ST_FULL;
                o_id_nxt   = '0;
              end else begin
                ins_id_nxt  = nid_r;
                ins_exp_nxt = shift_t(now_r, delay_r);
                o_id_nxt    = 16'(nid_r);
                nid_nxt     = nid_r + 1'b1;
                state_nxt   = S_INSERT;
              end
            end
            OP_ADJUST, OP_REMOVE: begin
              if (!hit) begin
                o_stat_nxt = ST_NOTFOUND;
              end else begin
                pos_nxt     = hit_pos;
                ins_id_nxt  = c_id[hit_pos];
                ins_exp_nxt = shift_t(c_exp[hit_pos], delay_r);
                o_fired_nxt = (op_r == OP_REMOVE) && fire_r;
                state_nxt   = S_DELETE;
              end
            end
            OP_CLEAR: begin
              cmd       = CMD_CLEAR;
              count_nxt = '0;
              nid_nxt   = '0;
              o_id_nxt  = '0;
            end
            OP_POLL: begin
              pos_nxt   = '0;
              state_nxt = S_POLL;
            end
            default: o_id_nxt = '0;
          endcase
        end
      end
      S_DELETE: begin
        cmd       = CMD_DELETE;
        count_nxt = count_r - 1'b1;
        state_nxt = (op_r == OP_ADJUST) ? S_INSERT : S_OUT;
      end
      S_INSERT: begin
        cmd       = CMD_INSERT;
        count_nxt = count_r + 1'b1;
        state_nxt = S_OUT;
      end
      S_POLL: begin
        if (!o_valid_nxt) begin
          o_stat_nxt  = ST_OK;
          o_fired_nxt = 1'b0;
          o_wait_nxt  = '0;
          if (c_valid[0] && (nfire_r < FW'(MAX_FIRE)) && (c_exp[0] <= now_r)) begin
            o_valid_nxt = 1'b1;
            o_kind_nxt  = KIND_FIRE;
            o_id_nxt    = 16'(c_id[0]);
            o_last_nxt  = 1'b0;
            pos_nxt     = '0;
            cmd         = CMD_DELETE;
            count_nxt   = count_r - 1'b1;
            nfire_nxt   = nfire_r + 1'b1;
          end else begin
            o_valid_nxt = 1'b1;
            o_kind_nxt  = KIND_END;
            o_id_nxt    = '0;
            o_last_nxt  = 1'b1;
            if (c_valid[0] && (c_exp[0] > now_r)) begin
              o_wait_nxt = (head_diff > TIME_BITS'(WAIT_MAX)) ? WAIT_MAX : 31'(head_diff);
            end
            state_nxt = S_IDLE;
          end
        end
      end
      S_OUT: begin
        o_valid_nxt = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      nid_r     <= '0;
      o_valid_r <= 1'b0;
      nfire_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      nid_r     <= nid_nxt;
      o_valid_r <= o_valid_nxt;
      nfire_r   <= nfire_nxt;
    end
    if (state_r == S_IDLE && in_valid) begin
      op_r    <= in_opcode;
      now_r   <= TIME_BITS'(in_current_ms);
      tid_r   <= ID_BITS'(in_task_id);
      delay_r <= in_delay_ms;
      fire_r  <= in_fire_on_remove;
    end
    pos_r     <= pos_nxt;
    ins_id_r  <= ins_id_nxt;
    ins_exp_r <= ins_exp_nxt;
    o_kind_r  <= o_kind_nxt;
    o_stat_r  <= o_stat_nxt;
    o_id_r    <= o_id_nxt;
    o_fired_r <= o_fired_nxt;
    o_wait_r  <= o_wait_nxt;
    o_last_r  <= o_last_nxt;
  end

endmodule
`default_nettype wire
